/* src/cfr_pkg.sv */
// Package for the command frame receiver: frame layout, status codes,
// duty laws and the byte-wide CRC-32 update. No dependencies.
package cfr_pkg;

	// Transfer and frame layout
	localparam int XFER_BYTES_DEF = 64;
	localparam int FRAME_LEN      = 15;
	localparam int CRC_LEN        = 11;
	localparam int FRAME_IDX_W    = 4;

	localparam logic [15:0] CMD_MAGIC   = 16'hBEEF;
	localparam logic [7:0]  CMD_VERSION = 8'd1;

	// Duty laws, permille
	localparam logic [9:0]  DUTY_MAX    = 10'd1000;
	localparam logic [9:0]  PI_DUTY     = 10'd300;
	localparam logic [9:0]  IDAPBC_DUTY = 10'd400;
	localparam logic [9:0]  DUTY_RESET  = 10'd200;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_MAGIC   = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BAD_CRC     = 3'd3,
		ST_BAD_MODE    = 3'd4,
		ST_SHORT       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_DUTY   = 2'd0,
		MODE_PI     = 2'd1,
		MODE_IDAPBC = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Reflected CRC-32, one byte per call
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	// Mode 0 law: clamp a received 16-bit duty to the full-scale value
	function automatic logic [9:0] clamp_duty(input logic [15:0] d);
		if (d > {6'd0, DUTY_MAX}) begin
			return DUTY_MAX;
		end
		return d[9:0];
	endfunction

endpackage

/* src/command_frame_receiver.sv */
// Command frame receiver: byte stream in, one status word per transfer out.
// Depends on cfr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one received byte per word,
//   rx_byte plus last_byte marking the final byte of the SPI transfer. A
//   transfer also ends on its XFER_BYTES-th byte. The first 15 bytes form the
//   command frame; later bytes are ignored apart from counting.
//   Output channel (out_valid/out_ready) carries one word per ended transfer:
//   status, mode_switched, active_mode and the applied duties.
//   Throughput: one byte per cycle, save for the stall below. Each byte goes
//   through an input register and then a single stage holding the byte-wide
//   CRC update, frame capture and checks, which writes the result register.
//   Result: the word is written to the result register when that stage takes
//   the last byte of a transfer from the input register.
//   Stall: while a result word waits on out_ready, bytes that do not end a
//   transfer keep flowing; a transfer-ending byte waits in the input
//   register, and in_ready drops once that register is held.
//   Reset: position and CRC restart, stored mode is duty mode, stored duties
//   are 200 each, and both channels are empty.
module command_frame_receiver #(
	parameter int XFER_BYTES = cfr_pkg::XFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       mode_switched,
	output logic [1:0] active_mode,
	output logic [9:0] duty_u,
	output logic [9:0] duty_v,
	output logic [9:0] duty_w
);
	import cfr_pkg::*;

	localparam int POS_W = $clog2(XFER_BYTES + 1);

	// Input register
	logic       s1_valid;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Transfer state
	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	logic [7:0]       frame_q [FRAME_LEN];
	mode_t            mode_q;
	logic [9:0]       duty_q [3];

	// Result register
	logic       out_valid_q;
	status_t    status_q;
	logic       changed_q;
	mode_t      active_q;
	logic [9:0] duty_out_q [3];

	logic [POS_W-1:0] pos_inc;
	logic             in_frame;
	logic             in_crc;
	logic             s1_end;
	logic             out_free;
	logic             s1_fire;
	logic [31:0]      crc_nxt;
	logic [7:0]       frame_nxt [FRAME_LEN];
	logic [31:0]      rx_crc;
	status_t          status_nxt;
	logic             accept;
	mode_t            mode_nxt;
	logic [9:0]       duty_nxt [3];
	logic [9:0]       duty_app [3];

	// Position and end of transfer
	assign pos_inc  = pos_q + POS_W'(1);
	assign in_frame = pos_q < POS_W'(FRAME_LEN);
	assign in_crc   = pos_q < POS_W'(CRC_LEN);
	assign s1_end   = last_s1 || (pos_inc == POS_W'(XFER_BYTES));

	// Handshake: a transfer-ending word needs a free result slot
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid && (!s1_end || out_free);
	assign in_ready = !s1_valid || s1_fire;

	// Running CRC and frame with the current byte folded in
	assign crc_nxt = in_crc ? crc_byte(crc_q, byte_s1) : crc_q;

	always_comb begin
		for (int i = 0; i < FRAME_LEN; i++) begin
			frame_nxt[i] = frame_q[i];
		end
		if (in_frame) begin
			frame_nxt[pos_q[FRAME_IDX_W-1:0]] = byte_s1;
		end
	end

	assign rx_crc = {frame_nxt[14], frame_nxt[13], frame_nxt[12], frame_nxt[11]};

	// Frame checks, first failure wins
	always_comb begin
		if (pos_inc < POS_W'(FRAME_LEN)) begin
			status_nxt = ST_SHORT;
		end else if ({frame_nxt[1], frame_nxt[0]} != CMD_MAGIC) begin
			status_nxt = ST_BAD_MAGIC;
		end else if (frame_nxt[2] != CMD_VERSION) begin
			status_nxt = ST_BAD_VERSION;
		end else if (~crc_nxt != rx_crc) begin
			status_nxt = ST_BAD_CRC;
		end else if (frame_nxt[3] > 8'(MODE_IDAPBC)) begin
			status_nxt = ST_BAD_MODE;
		end else begin
			status_nxt = ST_OK;
		end
	end

	assign accept = (status_nxt == ST_OK);

	// Stored command after this transfer
	always_comb begin
		mode_nxt = mode_q;
		for (int i = 0; i < 3; i++) begin
			duty_nxt[i] = duty_q[i];
		end
		if (accept) begin
			mode_nxt = mode_t'(frame_nxt[3][1:0]);
			for (int i = 0; i < 3; i++) begin
				duty_nxt[i] = clamp_duty({frame_nxt[6 + 2*i], frame_nxt[5 + 2*i]});
			end
		end
	end

	// Applied duties for the stored mode
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (mode_nxt)
				MODE_DUTY:   duty_app[i] = duty_nxt[i];
				MODE_PI:     duty_app[i] = PI_DUTY;
				MODE_IDAPBC: duty_app[i] = IDAPBC_DUTY;
				default:     duty_app[i] = '0;
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
			mode_q      <= MODE_DUTY;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				duty_q[i] <= DUTY_RESET;
			end
		end else begin
			if (in_ready) begin
				s1_valid <= in_valid;
			end
			if (s1_fire) begin
				if (s1_end) begin
					pos_q  <= '0;
					crc_q  <= CRC_INIT;
					mode_q <= mode_nxt;
					for (int i = 0; i < 3; i++) begin
						duty_q[i] <= duty_nxt[i];
					end
				end else begin
					pos_q <= pos_inc;
					crc_q <= crc_nxt;
				end
			end
			if (s1_fire && s1_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			last_s1 <= last_byte;
		end
		if (s1_fire && in_frame) begin
			frame_q[pos_q[FRAME_IDX_W-1:0]] <= byte_s1;
		end
		if (s1_fire && s1_end) begin
			status_q  <= status_nxt;
			changed_q <= accept && (mode_nxt != mode_q);
			active_q  <= mode_nxt;
			for (int i = 0; i < 3; i++) begin
				duty_out_q[i] <= duty_app[i];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign mode_switched = changed_q;
	assign active_mode   = active_q;
	assign duty_u        = duty_out_q[0];
	assign duty_v        = duty_out_q[1];
	assign duty_w        = duty_out_q[2];

endmodule
